// File: hw/rtl/sfhs_pkg.sv
package sfhs_pkg;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;

    localparam int DEG_W    = 16;
    localparam int PHASE_W  = 20;
    // floor(deg*64/45) via reciprocal: deg * ceil(2^28/45) >> 22, exact for 16-bit deg
    localparam int RECIP_W  = 23;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 23'd5965233;
    localparam int RECIP_SHIFT = 22;
    localparam int PROD_W   = DEG_W + RECIP_W;
    localparam int QUOT_W   = 17;

    localparam logic [3:0] FULL_FWD [4] = '{4'd1, 4'd2, 4'd4, 4'd8};
    localparam logic [3:0] FULL_REV [4] = '{4'd8, 4'd4, 4'd2, 4'd1};
    localparam logic [3:0] HALF_FWD [8] = '{4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9};
    localparam logic [3:0] HALF_REV [8] = '{4'd9, 4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1};

    typedef struct packed {
        logic [1:0]       func;
        logic             step_mode;
        logic             direction;
        logic [7:0]       hold_ms;
        logic [DEG_W-1:0] degrees;
    } t_item;

    typedef struct packed {
        logic [3:0] coils;
        logic       busy_res;
        logic       accepted;
        logic       move_done;
    } t_result;

    function automatic logic [3:0] pattern_at(input logic half, input logic rev,
                                              input logic [2:0] idx);
        logic [3:0] pat;
        if (half) begin
            pat = rev ? HALF_REV[idx] : HALF_FWD[idx];
        end else begin
            pat = rev ? FULL_REV[idx[1:0]] : FULL_FWD[idx[1:0]];
        end
        return pat;
    endfunction

endpackage

// File: hw/rtl/sfhs_if.sv
interface sfhs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic        step_mode;
    logic        direction;
    logic [7:0]  hold_ms;
    logic [15:0] degrees;

    modport source (output valid, output func, output step_mode, output direction,
                    output hold_ms, output degrees, input ready);
    modport sink (input valid, input func, input step_mode, input direction,
                  input hold_ms, input degrees, output ready);
endinterface

interface sfhs_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] coils;
    logic       busy_res;
    logic       accepted;
    logic       move_done;

    modport source (output valid, output coils, output busy_res, output accepted,
                    output move_done, input ready);
    modport sink (input valid, input coils, input busy_res, input accepted,
                  input move_done, output ready);
endinterface

// File: hw/rtl/sfhs_phase_calc.sv
module sfhs_phase_calc (
    input  logic [sfhs_pkg::DEG_W-1:0]   i_degrees,
    input  logic                         i_half,
    output logic [sfhs_pkg::PHASE_W-1:0] o_phases,
    output logic                         o_nonzero
);
    import sfhs_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;

    // both modes reduce to floor(deg*64/45) scaled by the sequence length
    assign prod      = PROD_W'(i_degrees) * PROD_W'(RECIP_MULT);
    assign quot      = prod[RECIP_SHIFT +: QUOT_W];
    assign o_phases  = i_half ? {quot, 3'b000} : {1'b0, quot, 2'b00};
    assign o_nonzero = (quot != '0);

endmodule

// File: hw/rtl/sfhs_core.sv
module sfhs_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  sfhs_pkg::t_item   i_item,
    output sfhs_pkg::t_result o_res
);
    import sfhs_pkg::*;

    logic               r_running, n_running;
    logic               r_half, n_half;
    logic               r_reverse, n_reverse;
    logic [7:0]         r_hold_length, n_hold_length;
    logic [7:0]         r_hold_count, n_hold_count;
    logic [2:0]         r_idx, n_idx;
    logic [PHASE_W-1:0] r_phases_left, n_phases_left;
    logic [3:0]         r_coil, n_coil;
    logic               n_acc;
    logic               n_done;

    logic [PHASE_W-1:0] start_phases;
    logic               start_nz;
    logic [7:0]         hc_inc;
    logic [PHASE_W-1:0] pl_dec;
    logic [2:0]         idx_inc;

    sfhs_phase_calc u_phase_calc (
        .i_degrees (i_item.degrees),
        .i_half    (i_item.step_mode),
        .o_phases  (start_phases),
        .o_nonzero (start_nz)
    );

    assign hc_inc  = r_hold_count + 8'd1;
    assign pl_dec  = r_phases_left - PHASE_W'(1);
    assign idx_inc = r_half ? (r_idx + 3'd1) : {1'b0, r_idx[1:0] + 2'd1};

    always_comb begin
        n_running     = r_running;
        n_half        = r_half;
        n_reverse     = r_reverse;
        n_hold_length = r_hold_length;
        n_hold_count  = r_hold_count;
        n_idx         = r_idx;
        n_phases_left = r_phases_left;
        n_coil        = r_coil;
        n_acc         = 1'b0;
        n_done        = 1'b0;
        case (i_item.func)
            FUNC_START: begin
                // a zero-phase start leaves everything alone
                if (start_nz) begin
                    n_running     = 1'b1;
                    n_half        = i_item.step_mode;
                    n_reverse     = i_item.direction;
                    n_hold_length = (i_item.hold_ms == 8'd0) ? 8'd1 : i_item.hold_ms;
                    n_hold_count  = 8'd0;
                    n_idx         = 3'd0;
                    n_phases_left = start_phases;
                    n_coil        = pattern_at(i_item.step_mode, i_item.direction, 3'd0);
                    n_acc         = 1'b1;
                end
            end
            FUNC_TICK: begin
                if (r_running) begin
                    if (hc_inc >= r_hold_length) begin
                        n_hold_count  = 8'd0;
                        n_phases_left = pl_dec;
                        if (pl_dec == '0) begin
                            n_running = 1'b0;
                            n_done    = 1'b1;
                        end else begin
                            n_idx  = idx_inc;
                            n_coil = pattern_at(r_half, r_reverse, idx_inc);
                        end
                    end else begin
                        n_hold_count = hc_inc;
                    end
                end
            end
            FUNC_STOP: begin
                n_running     = 1'b0;
                n_hold_count  = 8'd0;
                n_idx         = 3'd0;
                n_phases_left = '0;
                n_coil        = 4'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running     <= 1'b0;
            r_half        <= 1'b0;
            r_reverse     <= 1'b0;
            r_hold_length <= 8'd0;
            r_hold_count  <= 8'd0;
            r_idx         <= 3'd0;
            r_phases_left <= '0;
            r_coil        <= 4'd0;
        end else if (i_step) begin
            r_running     <= n_running;
            r_half        <= n_half;
            r_reverse     <= n_reverse;
            r_hold_length <= n_hold_length;
            r_hold_count  <= n_hold_count;
            r_idx         <= n_idx;
            r_phases_left <= n_phases_left;
            r_coil        <= n_coil;
        end
    end

    assign o_res = '{coils: n_coil, busy_res: n_running, accepted: n_acc, move_done: n_done};

endmodule

// File: hw/rtl/stepper_full_half_step_sequencer.sv
// channel | dir | fields                                          | transfer
// i_cmd   | in  | func, step_mode, direction, hold_ms, degrees    | valid & ready
// o_res   | out | coils, busy_res, accepted, move_done            | valid & ready
//
// one item per cycle sustained while o_res accepts; each item passes through
// the input register, then state update and phase multiply into the result register
// synchronous active-low reset clears the sequencer state, coils off
// a stalled result holds the pipe; i_cmd.ready drops only when both stages are full
module stepper_full_half_step_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfhs_in_if.sink     i_cmd,
    sfhs_out_if.source  o_res
);
    import sfhs_pkg::*;

    t_item   r_item;
    logic    r_item_vld;
    t_result r_res;
    logic    r_res_vld;
    t_result core_res;
    logic    res_free;
    logic    step;
    logic    in_xfer;

    assign res_free    = !r_res_vld || o_res.ready;
    assign step        = r_item_vld && res_free;
    assign i_cmd.ready = !r_item_vld || res_free;
    assign in_xfer     = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_res_vld  <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_item_vld <= 1'b1;
            end else if (step) begin
                r_item_vld <= 1'b0;
            end
            if (res_free) begin
                r_res_vld <= r_item_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= '{func: i_cmd.func, step_mode: i_cmd.step_mode,
                        direction: i_cmd.direction, hold_ms: i_cmd.hold_ms,
                        degrees: i_cmd.degrees};
        end
        if (step) begin
            r_res <= core_res;
        end
    end

    sfhs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_item),
        .o_res   (core_res)
    );

    assign o_res.valid     = r_res_vld;
    assign o_res.coils     = r_res.coils;
    assign o_res.busy_res  = r_res.busy_res;
    assign o_res.accepted  = r_res.accepted;
    assign o_res.move_done = r_res.move_done;

    // a started move is always running after its start
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.accepted |-> o_res.busy_res)
        else $error("accepted start without busy");

    // the end of a move leaves the sequencer idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.move_done |-> !o_res.busy_res && !o_res.accepted)
        else $error("move_done while busy or accepted");

    // a held item is not dropped while the result side stalls
    a_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_item_vld && !step |=> r_item_vld && $stable(r_item))
        else $error("pending item lost");

    // a stop leaves the coils off and the sequencer idle
    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_item.func == FUNC_STOP |=> r_res.coils == 4'd0 && !r_res.busy_res)
        else $error("stop did not de-energize coils");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import sfhs_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;

    sfhs_in_if  cmd_if ();
    sfhs_out_if res_if ();

    stepper_full_half_step_sequencer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // sequencer state as predicted
    logic        mv_run;
    logic        mv_half;
    logic        mv_rev;
    logic [7:0]  mv_hold_len;
    logic [7:0]  mv_hold_cnt;
    logic [2:0]  mv_idx;
    logic [19:0] mv_left;
    logic [3:0]  mv_coils;

    t_result pending_res_q[$];
    int      err_cnt;
    int      sent_cnt;
    int      res_cnt;
    int      idle_cyc;
    int      stall_left;
    bit      no_gaps;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [3:0] coil_table(input logic half, input logic rev,
                                              input logic [2:0] idx);
        logic [2:0] pos;
        logic [3:0] pat;
        // reverse sequences are the forward ones read backward
        if (half) begin
            pos = rev ? 3'd7 - idx : idx;
            case (pos)
                3'd0: pat = 4'd1;
                3'd1: pat = 4'd3;
                3'd2: pat = 4'd2;
                3'd3: pat = 4'd6;
                3'd4: pat = 4'd4;
                3'd5: pat = 4'd12;
                3'd6: pat = 4'd8;
                default: pat = 4'd9;
            endcase
        end else begin
            pos = {1'b0, rev ? 2'd3 - idx[1:0] : idx[1:0]};
            pat = 4'd1 << pos[1:0];
        end
        return pat;
    endfunction

    function automatic t_result advance_sequencer(input t_item c);
        t_result     r;
        logic [31:0] d32;
        logic [31:0] n_ph;
        r = '0;
        d32 = {16'd0, c.degrees};
        case (c.func)
            FUNC_START: begin
                if (c.step_mode) n_ph = ((d32 * 32'd512) / 32'd45 / 32'd8) * 32'd8;
                else n_ph = ((d32 * 32'd256) / 32'd45 / 32'd4) * 32'd4;
                // zero phases leaves everything as it was
                if (n_ph != 0) begin
                    mv_run      = 1'b1;
                    mv_half     = c.step_mode;
                    mv_rev      = c.direction;
                    mv_hold_len = (c.hold_ms == 8'd0) ? 8'd1 : c.hold_ms;
                    mv_hold_cnt = 8'd0;
                    mv_idx      = 3'd0;
                    mv_left     = n_ph[19:0];
                    mv_coils    = coil_table(mv_half, mv_rev, 3'd0);
                    r.accepted  = 1'b1;
                end
            end
            FUNC_TICK: begin
                if (mv_run) begin
                    mv_hold_cnt = mv_hold_cnt + 8'd1;
                    if (mv_hold_cnt >= mv_hold_len) begin
                        mv_hold_cnt = 8'd0;
                        mv_left = mv_left - 20'd1;
                        if (mv_left == 20'd0) begin
                            mv_run = 1'b0;
                            r.move_done = 1'b1;
                        end else begin
                            mv_idx = mv_half ? mv_idx + 3'd1 : {1'b0, mv_idx[1:0] + 2'd1};
                            mv_coils = coil_table(mv_half, mv_rev, mv_idx);
                        end
                    end
                end
            end
            FUNC_STOP: begin
                mv_run      = 1'b0;
                mv_hold_cnt = 8'd0;
                mv_idx      = 3'd0;
                mv_left     = 20'd0;
                mv_coils    = 4'd0;
            end
            default: ;
        endcase
        r.coils    = mv_coils;
        r.busy_res = mv_run;
        return r;
    endfunction

    // mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic t_item mk_cmd(input logic [1:0] func, input logic mode,
                                     input logic dir, input logic [7:0] hold,
                                     input logic [15:0] deg);
        t_item c;
        c.func      = func;
        c.step_mode = mode;
        c.direction = dir;
        c.hold_ms   = hold;
        c.degrees   = deg;
        return c;
    endfunction

    function automatic t_item noise_cmd(input logic [1:0] func);
        return mk_cmd(func, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        $display("mismatch at result %0d: %s got %0d want %0d", res_cnt, what, got, want);
        err_cnt++;
    endtask

    task automatic push_cmd(input t_item c);
        int gap;
        gap = (no_gaps || $urandom_range(0, 99) < 60) ? 0 : gap_len();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.func      <= c.func;
        cmd_if.step_mode <= c.step_mode;
        cmd_if.direction <= c.direction;
        cmd_if.hold_ms   <= c.hold_ms;
        cmd_if.degrees   <= c.degrees;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        pending_res_q.push_back(advance_sequencer(c));
        sent_cnt++;
    endtask

    // result sink with random stalls
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            res_if.ready  <= 1'b0;
        end else if (!no_gaps && $urandom_range(0, 99) < 25) begin
            stall_left    <= gap_len() - 1;
            res_if.ready  <= 1'b0;
        end else begin
            res_if.ready  <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : chk
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_res_q.size() == 0) begin
                flag_mismatch("unexpected transfer, coils", res_if.coils, 0);
            end else begin
                want = pending_res_q.pop_front();
                if (res_if.coils !== want.coils)
                    flag_mismatch("coils", res_if.coils, want.coils);
                if (res_if.busy_res !== want.busy_res)
                    flag_mismatch("busy_res", res_if.busy_res, want.busy_res);
                if (res_if.accepted !== want.accepted)
                    flag_mismatch("accepted", res_if.accepted, want.accepted);
                if (res_if.move_done !== want.move_done)
                    flag_mismatch("move_done", res_if.move_done, want.move_done);
            end
            res_cnt++;
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cyc <= 0;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
        if (idle_cyc >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cyc);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_directed();
        push_cmd(mk_cmd(FUNC_TICK, 1'b1, 1'b1, 8'd255, 16'd65535));
        push_cmd(mk_cmd(FUNC_STOP, 1'b0, 1'b0, 8'd0, 16'd0));
        push_cmd(mk_cmd(FUNC_UNUSED, 1'b1, 1'b1, 8'd255, 16'd65535));
        push_cmd(mk_cmd(FUNC_START, 1'b0, 1'b0, 8'd0, 16'd0));
        // shortest full step move, zero hold taken as one tick
        push_cmd(mk_cmd(FUNC_START, 1'b0, 1'b0, 8'd0, 16'd1));
        repeat (5) push_cmd(noise_cmd(FUNC_TICK));
        push_cmd(mk_cmd(FUNC_START, 1'b1, 1'b1, 8'd1, 16'd1));
        repeat (3) push_cmd(noise_cmd(FUNC_TICK));
        // zero-angle start must not disturb the running move
        push_cmd(mk_cmd(FUNC_START, 1'b1, 1'b0, 8'd7, 16'd0));
        push_cmd(noise_cmd(FUNC_UNUSED));
        push_cmd(noise_cmd(FUNC_TICK));
        push_cmd(mk_cmd(FUNC_START, 1'b0, 1'b1, 8'd255, 16'd65535));
        repeat (2) push_cmd(noise_cmd(FUNC_TICK));
        push_cmd(mk_cmd(FUNC_START, 1'b1, 1'b0, 8'd2, 16'd65535));
        repeat (3) push_cmd(noise_cmd(FUNC_TICK));
        push_cmd(noise_cmd(FUNC_STOP));
        push_cmd(noise_cmd(FUNC_TICK));
    endtask

    task automatic test_random_moves(input int n_items);
        int    base;
        int    ticks;
        int    r;
        t_item c;
        base = sent_cnt;
        while (sent_cnt - base < n_items) begin
            no_gaps = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 99);
            c = noise_cmd(FUNC_START);
            if (r < 85) begin
                c.degrees = 16'($urandom_range(1, 3));
                c.hold_ms = 8'($urandom_range(0, 2));
            end else if (r < 95) begin
                c.degrees = 16'($urandom_range(4, 20));
                c.hold_ms = 8'($urandom_range(0, 1));
            end
            push_cmd(c);
            ticks = 0;
            while (mv_run && ticks < 80) begin
                r = $urandom_range(0, 99);
                if (r < 94) begin
                    push_cmd(noise_cmd(FUNC_TICK));
                end else if (r < 96) begin
                    push_cmd(noise_cmd(FUNC_STOP));
                end else if (r < 98) begin
                    push_cmd(noise_cmd(FUNC_UNUSED));
                end else begin
                    c = noise_cmd(FUNC_START);
                    c.degrees = 16'($urandom_range(0, 2));
                    c.hold_ms = 8'($urandom_range(0, 2));
                    push_cmd(c);
                end
                ticks++;
            end
            if (mv_run) push_cmd(noise_cmd(FUNC_STOP));
            repeat ($urandom_range(0, 2)) push_cmd(noise_cmd(FUNC_TICK));
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_drain_pause();
        t_item c;
        c = mk_cmd(FUNC_START, 1'b1, 1'b0, 8'd0, 16'd1);
        push_cmd(c);
        repeat (4) push_cmd(noise_cmd(FUNC_TICK));
        // hold off until every result has come back
        cmd_if.valid <= 1'b0;
        while (pending_res_q.size() != 0) @(posedge i_clk);
        repeat (6) push_cmd(noise_cmd(FUNC_TICK));
        push_cmd(noise_cmd(FUNC_STOP));
    endtask

    task automatic test_noise(input int n_items);
        repeat (n_items) push_cmd(noise_cmd(2'($urandom_range(0, 3))));
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cmd_if.valid     = 1'b0;
        cmd_if.func      = FUNC_TICK;
        cmd_if.step_mode = 1'b0;
        cmd_if.direction = 1'b0;
        cmd_if.hold_ms   = 8'd0;
        cmd_if.degrees   = 16'd0;
        mv_run      = 1'b0;
        mv_half     = 1'b0;
        mv_rev      = 1'b0;
        mv_hold_len = 8'd0;
        mv_hold_cnt = 8'd0;
        mv_idx      = 3'd0;
        mv_left     = 20'd0;
        mv_coils    = 4'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_moves(300);
        test_drain_pause();
        test_noise(100);

        cmd_if.valid <= 1'b0;
        while (pending_res_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/sfhs_pkg.sv
hw/rtl/sfhs_if.sv
hw/rtl/sfhs_phase_calc.sv
hw/rtl/sfhs_core.sv
hw/rtl/stepper_full_half_step_sequencer.sv
test/tb_top.sv
